FILE: hdl/nearest_edge_crossover_macros.svh
// Assertion macros for the nearest edge crossover block
`ifndef NEAREST_EDGE_CROSSOVER_MACROS_SVH
`define NEAREST_EDGE_CROSSOVER_MACROS_SVH
`ifndef SYNTH
`define NEC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NEC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define NEC_ASSERT(lbl, clk, rst_n, prop, msg)
`define NEC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

FILE: hdl/nec_pkg.sv
// ----------------------------------------------------------------------------
// nec_pkg
// Shared constants and types of the nearest edge crossover block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package nec_pkg;
  localparam int MaxGenes  = 64;
  localparam int DistBits  = 24;
  localparam int NodeCount = MaxGenes + 1;
  localparam int NodeW     = 7;
  localparam int PosW      = 6;
  localparam int AddrW     = 13;

  typedef enum logic [1:0] {
    OP_LOAD_DIST = 2'd0,
    OP_LOAD_A    = 2'd1,
    OP_LOAD_B    = 2'd2,
    OP_RUN       = 2'd3
  } op_e;

  // sequencer to parent-store read request
  typedef struct packed {
    logic            rd;
    logic [PosW-1:0] addr;
  } gene_rd_t;

  function automatic logic is_customer(input logic [NodeW-1:0] g);
    return (g >= NodeW'(1)) && (g <= NodeW'(MaxGenes));
  endfunction
endpackage

FILE: hdl/nearest_edge_crossover.sv
// ----------------------------------------------------------------------------
// nearest_edge_crossover
// Greedy nearest-edge crossover of two customer permutations.
// ----------------------------------------------------------------------------
// Load requests (distance, parent A gene, parent B gene) are written at the
// accepting edge and can follow back to back. A run request emits N results
// on child_*_o, with strobe_o high for one cycle each (N = gene_count clamped
// to 2..64). The receiver cannot stall, so take them as they come. One
// sequencer and one shared compare path walk each parent's cyclic scan one
// gene per cycle through the registered parent memories. The first gene is
// A[0]; every further gene passes S_WHERE, S_SCAN and S_CHECK for A, then for
// B (scanning 1..N genes in each), then S_DIST, S_DWAIT and S_PICK. busy
// is high during a run but already low while the last gene is on the outputs.
`timescale 1ns / 1ps
module nearest_edge_crossover (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               operation_i,
  input  logic [6:0]               from_node_i,
  input  logic [6:0]               to_node_i,
  input  logic [23:0]              distance_value_i,
  input  logic [5:0]               gene_position_i,
  input  logic [6:0]               gene_value_i,
  input  logic                     cfg_we_i,
  input  logic [6:0]               cfg_wdata_i,
  output logic                     strobe_o,
  output logic [6:0]               child_gene_o,
  output logic [5:0]               child_position_o,
  output logic                     last_gene_o
);
  import nec_pkg::*;
  `include "nearest_edge_crossover_macros.svh"

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_FIRST = 8'b00000010,
    S_WHERE = 8'b00000100,
    S_SCAN  = 8'b00001000,
    S_CHECK = 8'b00010000,
    S_DIST  = 8'b00100000,
    S_DWAIT = 8'b01000000,
    S_PICK  = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  logic [NodeW-1:0] gcount_q;
  logic [NodeW-1:0] n_eff;
  logic [NodeW-1:0] cur_q, cand_q [2], fall_q [2];
  logic             side_q;           // 0 scanning A, 1 scanning B
  logic [PosW-1:0]  ptr_q;
  logic [NodeW-1:0] k_q;
  logic [PosW-1:0]  idx_q;
  logic [NodeCount-1:0] vis_q;
  logic [DistBits-1:0]  dist_mem [NodeCount*NodeCount];
  logic [DistBits-1:0]  drd_q, da_q;
  logic             dvalid_q;
  logic             req;

  assign busy  = (state_q != S_IDLE);
  assign req   = start && !busy;
  assign n_eff = (gcount_q > NodeW'(MaxGenes)) ? NodeW'(MaxGenes) :
                 (gcount_q < NodeW'(2)) ? NodeW'(2) : gcount_q;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gcount_q <= NodeW'(MaxGenes);
    end else if (cfg_we_i) begin
      gcount_q <= cfg_wdata_i;
    end
  end

  // parent stores
  gene_rd_t         grd;
  logic [NodeW-1:0] gene_a, gene_b, gene_s;
  logic [PosW-1:0]  where_a, where_b, where_s;
  logic [PosW-1:0]  p_sat;
  logic [PosW-1:0]  scan_base;
  logic [PosW-1:0]  nxt_pos;

  assign gene_s  = side_q ? gene_b : gene_a;
  assign where_s = side_q ? where_b : where_a;

  // scan start: position of cur, saturated to N-1; depot or invalid node starts at 0
  assign p_sat = (!is_customer(cur_q)) ? '0 :
                 ({1'b0, where_s} >= n_eff) ? PosW'(n_eff - 1'b1) : where_s;

  // cyclic next position after the one being scanned
  assign scan_base = (state_q == S_SCAN) ? p_sat : ptr_q;
  assign nxt_pos   = ({1'b0, scan_base} + 1'b1 >= n_eff) ? '0 : scan_base + 1'b1;

  always_comb begin
    grd.rd   = 1'b1;
    grd.addr = (state_q == S_IDLE) ? '0 : nxt_pos;
  end

  nec_parent_store u_pa (
    .clk_i(clk_i), .we_i(req && operation_i == OP_LOAD_A),
    .wpos_i(gene_position_i), .wval_i(gene_value_i), .grd_i(grd),
    .where_addr_i(cur_q), .gene_o(gene_a), .where_o(where_a));
  nec_parent_store u_pb (
    .clk_i(clk_i), .we_i(req && operation_i == OP_LOAD_B),
    .wpos_i(gene_position_i), .wval_i(gene_value_i), .grd_i(grd),
    .where_addr_i(cur_q), .gene_o(gene_b), .where_o(where_b));

  // distance table, one registered read port
  logic [AddrW-1:0] daddr;
  logic [AddrW-1:0] dwaddr;
  logic [NodeW-1:0] dcol;
  assign dcol   = (state_q == S_DIST) ? cand_q[0] : cand_q[1];
  assign daddr  = AddrW'(cur_q) * AddrW'(NodeCount) + AddrW'(dcol);
  assign dwaddr = AddrW'(from_node_i) * AddrW'(NodeCount) + AddrW'(to_node_i);
  always_ff @(posedge clk_i) begin
    if (req && operation_i == OP_LOAD_DIST && from_node_i <= NodeW'(MaxGenes) &&
        to_node_i <= NodeW'(MaxGenes)) begin
      dist_mem[dwaddr] <= distance_value_i[DistBits-1:0];
    end
    drd_q <= dist_mem[daddr];
  end
  logic dok;
  assign dok = (cur_q <= NodeW'(MaxGenes)) && (dcol <= NodeW'(MaxGenes));
  always_ff @(posedge clk_i) begin
    dvalid_q <= dok;
  end
  logic [DistBits-1:0] dval;
  assign dval = dvalid_q ? drd_q : '0;

  // sequencer
  logic hit;
  assign hit = is_customer(gene_s) && !vis_q[gene_s];
  logic last_pick;
  assign last_pick = ({1'b0, idx_q} + 2'd2 >= n_eff);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (req && operation_i == OP_RUN) state_d = S_FIRST;
      S_FIRST: state_d = (n_eff > NodeW'(1)) ? S_WHERE : S_IDLE;
      S_WHERE: state_d = S_SCAN;
      S_SCAN:  state_d = S_CHECK;
      S_CHECK: begin
        if (hit || k_q >= n_eff) begin
          state_d = side_q ? S_DIST : S_WHERE;
        end
      end
      S_DIST:  state_d = S_DWAIT;
      S_DWAIT: state_d = S_PICK;
      S_PICK:  state_d = last_pick ? S_IDLE : S_WHERE;
      default: state_d = S_IDLE;
    endcase
  end

  logic [NodeW-1:0] pick;
  assign pick = (da_q > dval) ? cand_q[1] : cand_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      vis_q            <= '0;
      cur_q            <= '0;
      side_q           <= 1'b0;
      strobe_o         <= 1'b0;
      idx_q            <= '0;
      ptr_q            <= '0;
      k_q              <= '0;
      cand_q[0]        <= '0;
      cand_q[1]        <= '0;
      fall_q[0]        <= '0;
      fall_q[1]        <= '0;
      da_q             <= '0;
      child_gene_o     <= '0;
      child_position_o <= '0;
      last_gene_o      <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          side_q <= 1'b0;
          ptr_q  <= '0;
          if (req && operation_i == OP_RUN) vis_q <= '0;
        end
        S_FIRST: begin
          // gene_a holds A[0]
          cur_q <= gene_a;
          if (is_customer(gene_a)) vis_q[gene_a] <= 1'b1;
          strobe_o         <= 1'b1;
          child_gene_o     <= gene_a;
          child_position_o <= '0;
          last_gene_o      <= 1'b0;
          idx_q            <= '0;
        end
        S_WHERE: ;
        S_SCAN: begin
          // position of cur is ready; read starts at p+1
          ptr_q <= nxt_pos;
          k_q   <= NodeW'(1);
        end
        S_CHECK: begin
          if (k_q == NodeW'(1)) fall_q[side_q] <= gene_s;
          if (hit) begin
            cand_q[side_q] <= gene_s;
          end else if (k_q >= n_eff) begin
            cand_q[side_q] <= (k_q == NodeW'(1)) ? gene_s : fall_q[side_q];
          end else begin
            k_q   <= k_q + 1'b1;
            ptr_q <= nxt_pos;
          end
          if (hit || k_q >= n_eff) side_q <= ~side_q;
        end
        S_DIST: ;
        S_DWAIT: da_q <= dval;
        S_PICK: begin
          cur_q <= pick;
          if (is_customer(pick)) vis_q[pick] <= 1'b1;
          strobe_o         <= 1'b1;
          child_gene_o     <= pick;
          child_position_o <= idx_q + 1'b1;
          last_gene_o      <= last_pick;
          idx_q            <= idx_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  `NEC_ASSERT(a_strobe_busy, clk_i, rst_ni, strobe_o |-> $past(busy), "strobe outside a run")
  `NEC_ASSERT_NEVER(a_no_req_busy, clk_i, rst_ni, req && busy, "request taken while busy")
  `NEC_ASSERT(a_last_end, clk_i, rst_ni, (strobe_o && last_gene_o) |-> !busy, "last gene mid-run")
endmodule

FILE: hdl/nec_parent_store.sv
// ----------------------------------------------------------------------------
// nec_parent_store
// One parent: gene array and position-of table, each with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module nec_parent_store (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [nec_pkg::PosW-1:0]  wpos_i,
  input  logic [nec_pkg::NodeW-1:0] wval_i,
  input  nec_pkg::gene_rd_t         grd_i,
  input  logic [nec_pkg::NodeW-1:0] where_addr_i,
  output logic [nec_pkg::NodeW-1:0] gene_o,
  output logic [nec_pkg::PosW-1:0]  where_o
);
  import nec_pkg::*;
  logic [NodeW-1:0] genes [MaxGenes];
  logic [PosW-1:0]  where [NodeCount];

  // gene array
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      genes[wpos_i] <= wval_i;
    end
    if (grd_i.rd) begin
      gene_o <= genes[grd_i.addr];
    end
  end

  // position-of table
  always_ff @(posedge clk_i) begin
    if (we_i && is_customer(wval_i)) begin
      where[wval_i] <= wpos_i;
    end
    if (where_addr_i <= NodeW'(MaxGenes)) begin
      where_o <= where[where_addr_i];
    end else begin
      where_o <= '0;
    end
  end
endmodule

FILE: tb/sv/tb_nearest_edge_crossover.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_edge_crossover
// Self-checking bench for the nearest edge crossover block. Loads the distance
// table and both parents, then fires run requests. An in-bench predictor
// builds each child and queues the genes it expects. A monitor compares every
// strobed gene with the oldest queued one.
// ----------------------------------------------------------------------------
module tb_nearest_edge_crossover;
  import nec_pkg::*;

  typedef struct packed {
    logic [6:0] gene;
    logic [5:0] pos;
    logic       last;
  } child_gene_t;

  // runs stay on nodes 0..SmallNodes, all of which get written up front
  localparam int SmallNodes = 6;
  localparam int ExpDepth   = 256;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  operation_i = '0;
  logic [6:0]  from_node_i = '0;
  logic [6:0]  to_node_i = '0;
  logic [23:0] distance_value_i = '0;
  logic [5:0]  gene_position_i = '0;
  logic [6:0]  gene_value_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [6:0]  cfg_wdata_i = '0;
  logic        strobe_o;
  logic [6:0]  child_gene_o;
  logic [5:0]  child_position_o;
  logic        last_gene_o;

  // shadow state of the block
  logic [23:0] dist_tbl [NodeCount*NodeCount];
  logic [6:0]  a_genes [MaxGenes];
  logic [6:0]  b_genes [MaxGenes];
  logic [5:0]  a_where [NodeCount];
  logic [5:0]  b_where [NodeCount];
  logic        visited [NodeCount];
  logic [6:0]  gene_cnt = 7'd64;

  // expected genes, oldest at exp_rd
  child_gene_t exp_mem [ExpDepth];
  int          exp_wr = 0;
  int          exp_rd = 0;
  int          n_err = 0;
  int          idle_pct = 0;
  int          n_sent = 0;

  nearest_edge_crossover i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .operation_i      (operation_i),
    .from_node_i      (from_node_i),
    .to_node_i        (to_node_i),
    .distance_value_i (distance_value_i),
    .gene_position_i  (gene_position_i),
    .gene_value_i     (gene_value_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .strobe_o         (strobe_o),
    .child_gene_o     (child_gene_o),
    .child_position_o (child_position_o),
    .last_gene_o      (last_gene_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  initial begin
    #2ms;
    $display("nearest_edge_crossover verification failed");
    $finish;
  end

  function automatic logic cust_ok(input logic [6:0] g);
    return (g >= 7'd1) && (g <= 7'(MaxGenes));
  endfunction

  function automatic logic [23:0] dist_of(input logic [6:0] f, input logic [6:0] t);
    if (f > 7'(MaxGenes) || t > 7'(MaxGenes)) return '0;
    return dist_tbl[int'(f) * NodeCount + int'(t)];
  endfunction

  function automatic void add_expected(input child_gene_t e);
    exp_mem[exp_wr % ExpDepth] = e;
    exp_wr++;
  endfunction

  // candidate of one parent: successor if free, else first free gene cyclically
  function automatic logic [6:0] next_free(input logic [6:0] genes [MaxGenes],
                                           input logic [5:0] where [NodeCount],
                                           input logic [6:0] cur, input int n);
    int p;
    logic [6:0] g;
    p = cust_ok(cur) ? int'(where[cur]) : 0;
    if (p >= n) p = n - 1;
    for (int k = 1; k <= n; k++) begin
      g = genes[(p + k) % n];
      if (cust_ok(g) && !visited[g]) return g;
    end
    return genes[(p + 1) % n];
  endfunction

  // greedy child build, queues one expected gene per position
  task automatic build_child();
    int n;
    logic [6:0] cur, ca, cb, pick;
    n = int'(gene_cnt);
    if (n > MaxGenes) n = MaxGenes;
    if (n < 2) n = 2;
    foreach (visited[i]) visited[i] = 1'b0;
    cur = a_genes[0];
    if (cust_ok(cur)) visited[cur] = 1'b1;
    add_expected(child_gene_t'{cur, 6'd0, 1'b0});
    for (int i = 1; i < n; i++) begin
      ca = next_free(a_genes, a_where, cur, n);
      cb = next_free(b_genes, b_where, cur, n);
      pick = (dist_of(cur, ca) > dist_of(cur, cb)) ? cb : ca;
      cur = pick;
      if (cust_ok(pick)) visited[pick] = 1'b1;
      add_expected(child_gene_t'{pick, 6'(i), i == n - 1});
    end
  endtask

  task automatic apply_req(input op_e op, input logic [6:0] f, input logic [6:0] t,
                           input logic [23:0] d, input logic [5:0] p,
                           input logic [6:0] v);
    case (op)
      OP_LOAD_DIST: begin
        if (f <= 7'(MaxGenes) && t <= 7'(MaxGenes)) dist_tbl[int'(f) * NodeCount + int'(t)] = d;
      end
      OP_LOAD_A: begin
        a_genes[p] = v;
        if (cust_ok(v)) a_where[v] = p;
      end
      OP_LOAD_B: begin
        b_genes[p] = v;
        if (cust_ok(v)) b_where[v] = p;
      end
      default: build_child();
    endcase
  endtask

  // drive one request, hold it until accepted, then optional idle gap
  task automatic send_req(input op_e op, input logic [6:0] f, input logic [6:0] t,
                          input logic [23:0] d, input logic [5:0] p,
                          input logic [6:0] v);
    start            <= 1'b1;
    operation_i      <= op;
    from_node_i      <= f;
    to_node_i        <= t;
    distance_value_i <= d;
    gene_position_i  <= p;
    gene_value_i     <= v;
    do @(posedge clk_i); while (busy);
    apply_req(op, f, t, d, p, v);
    n_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic load_dist(input logic [6:0] f, input logic [6:0] t, input logic [23:0] d);
    send_req(OP_LOAD_DIST, f, t, d, 6'($urandom), 7'($urandom));
  endtask

  task automatic load_gene(input op_e op, input logic [5:0] p, input logic [6:0] v);
    send_req(op, 7'($urandom), 7'($urandom), 24'($urandom), p, v);
  endtask

  task automatic run_child();
    send_req(OP_RUN, 7'($urandom), 7'($urandom), 24'($urandom), 6'($urandom), 7'($urandom));
  endtask

  // hold off until every queued gene is out and the block has gone quiet
  task automatic drain();
    start <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_gene_count(input logic [6:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    gene_cnt = v;
  endtask

  // shuffled permutation of 1..n into one parent
  task automatic load_perm(input op_e op, input int n);
    logic [6:0] perm [MaxGenes];
    int j;
    logic [6:0] tmp;
    for (int i = 0; i < n; i++) perm[i] = 7'(i + 1);
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
    end
    for (int i = 0; i < n; i++) load_gene(op, 6'(i), perm[i]);
  endtask

  // result monitor
  always @(posedge clk_i) begin
    child_gene_t exp_g;
    if (rst_ni && strobe_o) begin
      if (exp_wr == exp_rd) begin
        $error("child gene %0d at position %0d with nothing expected",
               child_gene_o, child_position_o);
        n_err++;
      end else begin
        exp_g = exp_mem[exp_rd % ExpDepth];
        exp_rd++;
        if (child_gene_o !== exp_g.gene) begin
          $error("child_gene expected %0d got %0d", exp_g.gene, child_gene_o);
          n_err++;
        end
        if (child_position_o !== exp_g.pos) begin
          $error("child_position expected %0d got %0d", exp_g.pos, child_position_o);
          n_err++;
        end
        if (last_gene_o !== exp_g.last) begin
          $error("last_gene expected %0d got %0d", exp_g.last, last_gene_o);
          n_err++;
        end
      end
    end
  end

  // table and both parents over the small node range, so no run reads an
  // unwritten entry
  task automatic test_fill_stores();
    for (int f = 0; f <= SmallNodes; f++)
      for (int t = 0; t <= SmallNodes; t++) load_dist(7'(f), 7'(t), 24'($urandom));
    load_perm(OP_LOAD_A, SmallNodes);
    load_perm(OP_LOAD_B, SmallNodes);
  endtask

  // gene count floor, tie, invalid genes, ignored loads
  task automatic test_directed();
    write_gene_count(7'd0);              // floor of two
    run_child();
    write_gene_count(7'd1);
    run_child();
    write_gene_count(7'd3);
    load_gene(OP_LOAD_A, 6'd0, 7'd1);
    load_gene(OP_LOAD_A, 6'd1, 7'd2);
    load_gene(OP_LOAD_A, 6'd2, 7'd3);
    load_gene(OP_LOAD_B, 6'd0, 7'd1);
    load_gene(OP_LOAD_B, 6'd1, 7'd3);
    load_gene(OP_LOAD_B, 6'd2, 7'd2);
    load_dist(7'd1, 7'd2, 24'hFFFFFF);
    load_dist(7'd1, 7'd3, 24'hFFFFFF);   // tie goes to A
    load_dist(7'd100, 7'd2, 24'd0);      // ignored, row out of range
    load_dist(7'd2, 7'd127, 24'd0);      // ignored, column out of range
    run_child();
    load_gene(OP_LOAD_A, 6'd1, 7'd0);    // invalid genes in A
    load_gene(OP_LOAD_A, 6'd2, 7'd127);
    load_dist(7'd1, 7'd3, 24'd0);
    run_child();
    load_gene(OP_LOAD_A, 6'd0, 7'd127);  // invalid first gene
    load_gene(OP_LOAD_B, 6'd63, 7'd64);
    run_child();
    write_gene_count(7'(SmallNodes));
  endtask

  // mostly well-formed trials on small sizes, some noise requests
  task automatic test_random(input int budget);
    int n, stop_at;
    stop_at = n_sent + budget;
    while (n_sent < stop_at) begin
      if ($urandom_range(99) < 15) begin
        // noise gene loads go to positions that no run reaches
        send_req(op_e'($urandom_range(0, 2)), 7'($urandom), 7'($urandom),
                 24'($urandom), 6'($urandom_range(SmallNodes + 2, MaxGenes - 1)),
                 7'($urandom));
      end else begin
        n = $urandom_range(2, SmallNodes);
        if (n != int'(gene_cnt)) write_gene_count(7'(n));
        if ($urandom_range(3) != 0) load_perm(OP_LOAD_A, n);
        if ($urandom_range(3) != 0) load_perm(OP_LOAD_B, n);
        repeat ($urandom_range(0, 6))
          load_dist(7'($urandom_range(0, n)), 7'($urandom_range(0, n)),
                    ($urandom_range(3) == 0) ? 24'($urandom_range(0, 3)) : 24'($urandom));
        run_child();
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_stores();
    idle_pct = 26;
    test_directed();
    test_random(50);
    drain();
    idle_pct = 52;
    test_random(45);
    drain();
    idle_pct = 0;
    test_random(45);
    drain();
    repeat (20) @(posedge clk_i);
    if (n_err == 0 && exp_wr == exp_rd) begin
      $display("nearest_edge_crossover verification clean");
    end else begin
      $display("nearest_edge_crossover verification failed");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+hdl
hdl/nec_pkg.sv
hdl/nec_parent_store.sv
hdl/nearest_edge_crossover.sv
tb/sv/tb_nearest_edge_crossover.sv
